// ===== src/fac_pkg.sv =====
package fac_pkg;

    // Box coordinate fields on the input channel
    localparam int COORD_IN_W      = 32;
    // Matrix entries and derived plane components
    localparam int ELEM_W          = 32;
    localparam int PLANE_W         = ELEM_W + 1;
    // Configuration port
    localparam int NUM_CFG         = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_W           = 2 * ELEM_W;
    localparam int NUM_PLANES      = 6;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Identity matrix in Q16.16 after reset
    localparam logic [CFG_W-1:0] CFG_RST [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // One frustum plane: normal and offset, exact sum or difference of two entries
    typedef struct packed {
        logic signed [PLANE_W-1:0] nx;
        logic signed [PLANE_W-1:0] ny;
        logic signed [PLANE_W-1:0] nz;
        logic signed [PLANE_W-1:0] w;
    } t_plane;

    // Stage enables handed to each plane pipeline
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } t_pipe_ctl;

endpackage

// ===== src/fac_box_if.sv =====
interface fac_box_if;
    import fac_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_IN_W-1:0] min_x;
    logic signed [COORD_IN_W-1:0] min_y;
    logic signed [COORD_IN_W-1:0] min_z;
    logic signed [COORD_IN_W-1:0] max_x;
    logic signed [COORD_IN_W-1:0] max_y;
    logic signed [COORD_IN_W-1:0] max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);

endinterface

// ===== src/fac_res_if.sv =====
interface fac_res_if;

    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);

endinterface

// ===== src/fac_plane.sv =====
module fac_plane #(
    parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  fac_pkg::t_pipe_ctl          i_ctl,
    input  fac_pkg::t_plane             i_plane,
    input  logic [2:0][COORD_WIDTH-1:0] i_lo,
    input  logic [2:0][COORD_WIDTH-1:0] i_hi,
    output logic                        o_reject
);
    import fac_pkg::*;

    localparam int PROD_W = PLANE_W + COORD_WIDTH;
    localparam int WSH_W  = PLANE_W + FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > WSH_W) ? PROD_W : WSH_W) + 2;

    logic signed [PLANE_W-1:0]     nrm [3];
    logic signed [COORD_WIDTH-1:0] vtx [3];
    logic signed [PROD_W-1:0]      n_prod [3];
    logic signed [WSH_W-1:0]       n_wsh;
    logic signed [PROD_W-1:0]      r_prod [3];
    logic signed [WSH_W-1:0]       r_wsh;
    logic signed [SUM_W-1:0]       r_sum_a;
    logic signed [SUM_W-1:0]       r_sum_b;
    logic signed [SUM_W-1:0]       total;

    assign nrm[0] = i_plane.nx;
    assign nrm[1] = i_plane.ny;
    assign nrm[2] = i_plane.nz;

    // Pick the positive vertex per axis and form the exact products
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vtx[c]    = nrm[c][PLANE_W-1] ? $signed(i_lo[c]) : $signed(i_hi[c]);
            n_prod[c] = PROD_W'(nrm[c]) * PROD_W'(vtx[c]);
        end
        n_wsh = WSH_W'(i_plane.w) <<< FRAC_BITS;
    end

    // Hold products for the adder stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= n_prod[c];
            end
            r_wsh <= n_wsh;
        end
    end

    // Add in pairs
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum_a <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]);
            r_sum_b <= SUM_W'(r_prod[2]) + SUM_W'(r_wsh);
        end
    end

    // Reject on a negative total; zero counts as inside
    assign total    = r_sum_a + r_sum_b;
    assign o_reject = total[SUM_W-1];

endmodule

// ===== src/frustum_aabb_cull.sv =====
// Stages are input, products, pair sums and the result register, which drives o_res.
// Throughput: one box per cycle while o_res does not stall.
// Each stage advances on its own, so bubbles close up when the result side stalls.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// Plane registers follow the matrix in the cycle after each configuration write.
module frustum_aabb_cull #(
    parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fac_box_if.sink                        i_box,
    fac_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fac_pkg::CFG_W-1:0]      i_cfg_data
);
    import fac_pkg::*;

    logic signed [ELEM_W-1:0]    r_mat [4][4];
    t_plane                      n_plane [NUM_PLANES];
    t_plane                      r_plane [NUM_PLANES];
    logic [2:0][COORD_WIDTH-1:0] r_lo;
    logic [2:0][COORD_WIDTH-1:0] r_hi;
    logic                        r_v0;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_out_vld;
    logic                        r_inside;
    logic                        rdy0;
    logic                        rdy1;
    logic                        rdy2;
    logic                        rdy3;
    t_pipe_ctl                   ctl;
    logic [NUM_PLANES-1:0]       reject;

    // Matrix registers: column from index bits 2:1, row pair from bit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_mat[2'(i >> 1)][{i[0], 1'b0}] <= CFG_RST[i][ELEM_W-1:0];
                r_mat[2'(i >> 1)][{i[0], 1'b1}] <= CFG_RST[i][CFG_W-1:ELEM_W];
            end
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b0}] <= i_cfg_data[ELEM_W-1:0];
            r_mat[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b1}] <= i_cfg_data[CFG_W-1:ELEM_W];
        end
    end

    // Derive planes: row 3 plus row k, then row 3 minus row k
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_plane[2*k].nx   = PLANE_W'(r_mat[0][3]) + PLANE_W'(r_mat[0][k]);
            n_plane[2*k].ny   = PLANE_W'(r_mat[1][3]) + PLANE_W'(r_mat[1][k]);
            n_plane[2*k].nz   = PLANE_W'(r_mat[2][3]) + PLANE_W'(r_mat[2][k]);
            n_plane[2*k].w    = PLANE_W'(r_mat[3][3]) + PLANE_W'(r_mat[3][k]);
            n_plane[2*k+1].nx = PLANE_W'(r_mat[0][3]) - PLANE_W'(r_mat[0][k]);
            n_plane[2*k+1].ny = PLANE_W'(r_mat[1][3]) - PLANE_W'(r_mat[1][k]);
            n_plane[2*k+1].nz = PLANE_W'(r_mat[2][3]) - PLANE_W'(r_mat[2][k]);
            n_plane[2*k+1].w  = PLANE_W'(r_mat[3][3]) - PLANE_W'(r_mat[3][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= n_plane;
    end

    // Each stage moves on when empty or when the next one moves
    assign rdy3        = !r_out_vld || o_res.ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign rdy0        = !r_v0 || rdy1;
    assign i_box.ready = rdy0;
    assign ctl.en_prod = rdy1;
    assign ctl.en_sum  = rdy2;

    // Valid flags along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy0) r_v0      <= i_box.valid;
            if (rdy1) r_v1      <= r_v0;
            if (rdy2) r_v2      <= r_v1;
            if (rdy3) r_out_vld <= r_v2;
        end
    end

    // Capture the box, low coordinate bits taken as signed
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_lo[0] <= i_box.min_x[COORD_WIDTH-1:0];
            r_lo[1] <= i_box.min_y[COORD_WIDTH-1:0];
            r_lo[2] <= i_box.min_z[COORD_WIDTH-1:0];
            r_hi[0] <= i_box.max_x[COORD_WIDTH-1:0];
            r_hi[1] <= i_box.max_y[COORD_WIDTH-1:0];
            r_hi[2] <= i_box.max_z[COORD_WIDTH-1:0];
        end
    end

    // One dot-product pipeline per plane
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fac_plane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_plane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_plane  (r_plane[p]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .o_reject (reject[p])
        );
    end

    // Result register: inside unless some plane rejects
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_inside <= ~|reject;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.inside_res = r_inside;

endmodule

// ===== test/frustum_aabb_cull_tb.sv =====
`timescale 1ns / 1ps

module frustum_aabb_cull_tb;
    import fac_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int PIPE_LAT    = 3;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 11;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] min_x;
        logic signed [COORD_IN_W-1:0] min_y;
        logic signed [COORD_IN_W-1:0] min_z;
        logic signed [COORD_IN_W-1:0] max_x;
        logic signed [COORD_IN_W-1:0] max_y;
        logic signed [COORD_IN_W-1:0] max_z;
    } t_box;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fac_box_if box_ch ();
    fac_res_if res_ch ();

    // Shadow of the matrix registers and the next setting to load
    logic [CFG_W-1:0] matrix_regs   [NUM_CFG];
    logic [CFG_W-1:0] staged_words  [NUM_CFG];

    t_box pending_boxes [$];
    bit   expected_inside [$];
    t_box next_box;
    bit   wanted;

    bit   calm      = 1'b0;
    logic hold_req  = 1'b0;
    int   hold_left = 0;

    int cycle_cnt      = 0;
    int mismatch_cnt   = 0;
    int boxes_sent     = 0;
    int results_seen   = 0;
    int inside_seen    = 0;
    int culled_seen    = 0;
    int settings_used  = 1;

    frustum_aabb_cull dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_box      (box_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Matrix entry M[col][row] from the register shadow
    function automatic logic signed [ELEM_W-1:0] mat_entry(int col, int row);
        return matrix_regs[2 * col + row / 2][ELEM_W * (row % 2) +: ELEM_W];
    endfunction

    // Expected visibility: positive-vertex test against all six planes, exact sums
    function automatic bit box_visible(t_box b);
        logic signed [COORD_IN_W-1:0] lo_c [3];
        logic signed [COORD_IN_W-1:0] hi_c [3];
        logic signed [COORD_IN_W-1:0] pick;
        logic signed [PLANE_W-1:0]    pl [4];
        logic signed [127:0]          acc;
        bit                           vis;
        vis  = 1'b1;
        lo_c = '{b.min_x, b.min_y, b.min_z};
        hi_c = '{b.max_x, b.max_y, b.max_z};
        for (int k = 0; k < 3; k++) begin
            for (int s = 0; s < 2; s++) begin
                for (int c = 0; c < 4; c++) begin
                    pl[c] = (s == 0) ? mat_entry(c, 3) + mat_entry(c, k)
                                     : mat_entry(c, 3) - mat_entry(c, k);
                end
                acc = pl[3];
                acc = acc <<< FRAC_BITS;
                for (int c = 0; c < 3; c++) begin
                    pick = (pl[c] >= 0) ? hi_c[c] : lo_c[c];
                    acc  = acc + pl[c] * pick;
                end
                if (acc < 0) begin
                    vis = 1'b0;
                end
            end
        end
        return vis;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    function automatic t_box cube(logic signed [31:0] lo, logic signed [31:0] hi);
        return t_box'{lo, lo, lo, hi, hi, hi};
    endfunction

    // Either fully random bits or a small box near the origin, sometimes swapped
    function automatic t_box rand_box(int full_pct);
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] ctr;
        logic signed [31:0] half;
        logic signed [31:0] tmp;
        if ($urandom_range(99) < full_pct) begin
            return t_box'{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        for (int a = 0; a < 3; a++) begin
            ctr   = $urandom_range(0, 8 * ONE) - 4 * ONE;
            half  = $urandom_range(0, ONE);
            lo[a] = ctr - half;
            hi[a] = ctr + half;
            if ($urandom_range(19) == 0) begin
                tmp   = lo[a];
                lo[a] = hi[a];
                hi[a] = tmp;
            end
        end
        return t_box'{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    endfunction

    // Entry within +/-2.0, zero about a quarter of the time
    function automatic logic [31:0] small_entry();
        if ($urandom_range(3) == 0) begin
            return '0;
        end
        return $urandom_range(0, 4 * ONE) - 2 * ONE;
    endfunction

    task automatic queue_random_boxes(int n, int full_pct);
        for (int i = 0; i < n; i++) begin
            pending_boxes.push_back(rand_box(full_pct));
        end
    endtask

    // Write every register from the staged set; only called with the pipeline empty
    task automatic load_staged();
        for (int i = 0; i < NUM_CFG; i++) begin
            @(posedge i_clk);
            i_cfg_we       <= 1'b1;
            i_cfg_idx      <= CFG_IDX_W'(i);
            i_cfg_data     <= staged_words[i];
            matrix_regs[i]  = staged_words[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic fill_small_matrix();
        for (int i = 0; i < NUM_CFG; i++) begin
            staged_words[i] = {small_entry(), small_entry()};
        end
    endtask

    task automatic fill_constant(logic [CFG_W-1:0] word);
        for (int i = 0; i < NUM_CFG; i++) begin
            staged_words[i] = word;
        end
    endtask

    // Wait for every queued box to go out and every result to come back, then settle
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_boxes.size() != 0 || expected_inside.size() != 0 || box_ch.valid);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Box driver: record each transfer, then offer the next pending box
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_ch.valid <= 1'b0;
            box_ch.min_x <= '0;
            box_ch.min_y <= '0;
            box_ch.min_z <= '0;
            box_ch.max_x <= '0;
            box_ch.max_y <= '0;
            box_ch.max_z <= '0;
        end else begin
            if (box_ch.valid && box_ch.ready) begin
                expected_inside.push_back(box_visible(t_box'{box_ch.min_x, box_ch.min_y,
                    box_ch.min_z, box_ch.max_x, box_ch.max_y, box_ch.max_z}));
                boxes_sent++;
            end
            if (!box_ch.valid || box_ch.ready) begin
                if (pending_boxes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_box = pending_boxes.pop_front();
                    box_ch.valid <= 1'b1;
                    box_ch.min_x <= next_box.min_x;
                    box_ch.min_y <= next_box.min_y;
                    box_ch.min_z <= next_box.min_z;
                    box_ch.max_x <= next_box.max_x;
                    box_ch.max_y <= next_box.max_y;
                    box_ch.max_z <= next_box.max_z;
                end else begin
                    box_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_inside.size() == 0) begin
                    report_mismatch($sformatf("unexpected result inside_res=%0b",
                                              res_ch.inside_res));
                end else begin
                    wanted = expected_inside.pop_front();
                    if (res_ch.inside_res !== wanted) begin
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  res_ch.inside_res, wanted));
                    end
                    if (wanted) begin
                        inside_seen++;
                    end else begin
                        culled_seen++;
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long hold-off on the result side, counted here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_inside.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        matrix_regs   = CFG_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity after reset: the cube from -1.0 to 1.0 on each axis is the frustum
        pending_boxes.push_back(cube(0, 0));
        pending_boxes.push_back(cube(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_boxes.push_back(cube(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pending_boxes.push_back(cube(32'sh8000_0000, 32'sh8000_0000));
        pending_boxes.push_back(cube(32'shFFFF_FFFF, 32'shFFFF_FFFF));
        pending_boxes.push_back(t_box'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                       32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA});
        // Touching a plane exactly counts as inside; one LSB further is culled
        pending_boxes.push_back(t_box'{-2 * ONE, 0, 0, -ONE, 0, 0});
        pending_boxes.push_back(t_box'{-2 * ONE, 0, 0, -ONE - 1, 0, 0});
        pending_boxes.push_back(t_box'{ONE, 0, 0, 2 * ONE, 0, 0});
        pending_boxes.push_back(t_box'{ONE + 1, 0, 0, 2 * ONE, 0, 0});
        pending_boxes.push_back(t_box'{0, -2 * ONE, 0, 0, -ONE, 0});
        pending_boxes.push_back(t_box'{0, ONE + 1, 0, 0, 2 * ONE, 0});
        pending_boxes.push_back(t_box'{0, 0, -2 * ONE, 0, 0, -ONE - 1});
        pending_boxes.push_back(t_box'{0, 0, ONE, 0, 0, 2 * ONE});
        // Swapped boxes are taken as given
        pending_boxes.push_back(t_box'{2 * ONE, 0, 0, -2 * ONE, 0, 0});
        pending_boxes.push_back(t_box'{ONE / 2, 0, 0, -ONE / 2, 0, 0});
        wait_drained();

        // Zero normals with negative w reject everything
        fill_constant('0);
        staged_words[7] = {32'shFFFF_0000, 32'sh0};
        load_staged();
        pending_boxes.push_back(cube(0, 0));
        pending_boxes.push_back(cube(32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_boxes.push_back(cube(-ONE, ONE));
        queue_random_boxes(30, 50);
        wait_drained();

        // Extreme matrices: plane components reach the ends of their range
        fill_constant({32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        load_staged();
        queue_random_boxes(100, 50);
        wait_drained();
        fill_constant({32'sh8000_0000, 32'sh8000_0000});
        load_staged();
        queue_random_boxes(100, 50);
        wait_drained();
        fill_constant({32'sh8000_0000, 32'sh7FFF_FFFF});
        staged_words[1] = {32'sh7FFF_FFFF, 32'sh8000_0000};
        staged_words[6] = {32'shFFFF_FFFF, 32'sh0000_0001};
        load_staged();
        queue_random_boxes(100, 50);
        wait_drained();

        // Realistic matrices with mostly small boxes near the origin; one pass calm, one with a long result hold-off
        for (int p = 0; p < 5; p++) begin
            fill_small_matrix();
            load_staged();
            calm = (p == 1);
            queue_random_boxes(220, 10);
            if (p == 3) begin
                @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            wait_drained();
        end
        calm = 1'b0;

        // Fully random matrix with a mix of fully random and small boxes
        for (int i = 0; i < NUM_CFG; i++) begin
            staged_words[i] = {$urandom, $urandom};
        end
        load_staged();
        queue_random_boxes(100, 60);

        do begin
            @(posedge i_clk);
        end while (pending_boxes.size() != 0 || box_ch.valid || expected_inside.size() != 0);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        if (expected_inside.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_inside.size()));
        end

        $display("Covered %0d boxes over %0d matrix settings, %0d results checked",
                 boxes_sent, settings_used, results_seen);
        $display("  %0d inside, %0d culled, %0d mismatches",
                 inside_seen, culled_seen, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
